[hw/rtl/alu8_pkg.sv]
`default_nettype none
package alu8_pkg;

	// Function codes of the ALU
	typedef enum logic [3:0] {
		OP_MOVA = 4'd0,
		OP_ADD  = 4'd1,
		OP_ADC  = 4'd2,
		OP_SUB  = 4'd3,
		OP_SBC  = 4'd4,
		OP_AND  = 4'd5,
		OP_NAND = 4'd6,
		OP_OR   = 4'd7,
		OP_NOR  = 4'd8,
		OP_XOR  = 4'd9,
		OP_NOTA = 4'd10,
		OP_ASL  = 4'd11,
		OP_ROL  = 4'd12,
		OP_ASR  = 4'd13,
		OP_ROR  = 4'd14,
		OP_NZVC = 4'd15
	} op_t;

	localparam int unsigned DataW = 8;
	localparam int unsigned SignBit = DataW - 1;

	// Decoded request, first stage to second
	typedef struct packed {
		logic             ok;
		op_t              op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] y;
		logic             ci;
	} dec_t;

	// Raw result, second stage to third
	typedef struct packed {
		logic             ok;
		logic             nzvc;
		logic [DataW-1:0] res;
		logic             v;
		logic             c;
		logic             alt_n;
		logic             alt_z;
	} exe_t;

	// Finished result
	typedef struct packed {
		logic [DataW-1:0] result_byte;
		logic             flag_n;
		logic             flag_z;
		logic             flag_v;
		logic             flag_c;
		logic             result_valid;
	} rsp_t;

endpackage
`default_nettype wire

[hw/rtl/alu8_req_if.sv]
`default_nettype none
interface alu8_req_if;
	import alu8_pkg::*;

	logic             valid;
	logic             ready;
	logic [3:0]       cmd;
	logic [DataW-1:0] operand_a;
	logic             a_present;
	logic [DataW-1:0] operand_b;
	logic             b_present;
	logic             carry_in;
	logic             carry_in_present;

	modport source (
		output valid, cmd, operand_a, a_present, operand_b, b_present,
			carry_in, carry_in_present,
		input  ready
	);
	modport sink (
		input  valid, cmd, operand_a, a_present, operand_b, b_present,
			carry_in, carry_in_present,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/alu8_rsp_if.sv]
`default_nettype none
interface alu8_rsp_if;
	import alu8_pkg::*;

	logic             valid;
	logic             ready;
	logic [DataW-1:0] result_byte;
	logic             flag_n;
	logic             flag_z;
	logic             flag_v;
	logic             flag_c;
	logic             result_valid;

	modport source (
		output valid, result_byte, flag_n, flag_z, flag_v, flag_c, result_valid,
		input  ready
	);
	modport sink (
		input  valid, result_byte, flag_n, flag_z, flag_v, flag_c, result_valid,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/eight_bit_alu_nzvc.sv]
// Three-stage pipelined 8-bit ALU with N, Z, V and C flags.
// An accepted request passes through the decode, execute and flag registers.
// Throughput: one request per cycle while rsp.ready holds; each stage has its
// own valid bit and takes a new request whenever empty or its content moves on.
// Reset clears the stage valid bits only; the datapath registers are not reset.
`default_nettype none
module eight_bit_alu_nzvc (
	input  wire logic   clk,
	input  wire logic   arst_n,
	alu8_req_if.sink    req,
	alu8_rsp_if.source  rsp
);
	import alu8_pkg::*;

	logic vld_1;
	logic rdy_1;
	dec_t dec;
	logic vld_2;
	logic rdy_2;
	exe_t exe;
	rsp_t res;

	// Decode and operand check
	alu8_dec u_dec (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (req.valid),
		.in_ready         (req.ready),
		.cmd              (req.cmd),
		.operand_a        (req.operand_a),
		.a_present        (req.a_present),
		.operand_b        (req.operand_b),
		.b_present        (req.b_present),
		.carry_in         (req.carry_in),
		.carry_in_present (req.carry_in_present),
		.out_valid        (vld_1),
		.out_ready        (rdy_1),
		.out_data         (dec)
	);

	// Arithmetic, logic and shifts
	alu8_exe u_exe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_1),
		.in_ready  (rdy_1),
		.in_data   (dec),
		.out_valid (vld_2),
		.out_ready (rdy_2),
		.out_data  (exe)
	);

	// Flags and output register
	alu8_flg u_flg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_2),
		.in_ready  (rdy_2),
		.in_data   (exe),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (res)
	);

	assign rsp.result_byte  = res.result_byte;
	assign rsp.flag_n       = res.flag_n;
	assign rsp.flag_z       = res.flag_z;
	assign rsp.flag_v       = res.flag_v;
	assign rsp.flag_c       = res.flag_c;
	assign rsp.result_valid = res.result_valid;
endmodule
`default_nettype wire

[hw/rtl/alu8_dec.sv]
`default_nettype none
module alu8_dec (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [3:0]            cmd,
	input  wire logic [alu8_pkg::DataW-1:0] operand_a,
	input  wire logic                  a_present,
	input  wire logic [alu8_pkg::DataW-1:0] operand_b,
	input  wire logic                  b_present,
	input  wire logic                  carry_in,
	input  wire logic                  carry_in_present,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output alu8_pkg::dec_t             out_data
);
	import alu8_pkg::*;

	op_t  op;
	logic unary;
	logic needs_c;
	dec_t dec;
	logic vld_s1;
	dec_t data_s1;

	assign op = op_t'(cmd);

	// Check operand presence and prepare the adder and shift inputs
	always_comb begin
		unary   = (op == OP_MOVA) || (op inside {[OP_NOTA:OP_NZVC]});
		needs_c = op inside {OP_ADC, OP_SBC, OP_ROL, OP_ROR};
		dec.ok  = a_present && (unary || b_present) && (!needs_c || carry_in_present);
		dec.op  = op;
		dec.a   = operand_a;
		dec.y   = (op inside {OP_SUB, OP_SBC}) ? ~operand_b : operand_b;
		case (op)
			OP_ADC, OP_SBC, OP_ROL, OP_ROR: dec.ci = carry_in;
			OP_SUB:                         dec.ci = 1'b1;
			OP_ASR:                         dec.ci = operand_a[SignBit];
			default:                        dec.ci = 1'b0;
		endcase
	end

	// Advance when the stage is empty or the next one takes its content
	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= dec;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = data_s1;
endmodule
`default_nettype wire

[hw/rtl/alu8_exe.sv]
`default_nettype none
module alu8_exe (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  alu8_pkg::dec_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output alu8_pkg::exe_t out_data
);
	import alu8_pkg::*;

	logic [DataW:0] sum;
	exe_t           exe;
	logic           vld_s2;
	exe_t           data_s2;

	assign sum = {1'b0, in_data.a} + {1'b0, in_data.y} + {{DataW{1'b0}}, in_data.ci};

	// Compute the result byte with its carry and overflow
	always_comb begin
		exe.ok    = in_data.ok;
		exe.nzvc  = 1'b0;
		exe.res   = '0;
		exe.v     = 1'b0;
		exe.c     = 1'b0;
		exe.alt_n = in_data.a[3];
		exe.alt_z = in_data.a[2];
		case (in_data.op)
			OP_MOVA: exe.res = in_data.a;
			OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
				exe.res = sum[DataW-1:0];
				exe.c   = sum[DataW];
				exe.v   = ~(in_data.a[SignBit] ^ in_data.y[SignBit])
					& (in_data.a[SignBit] ^ sum[SignBit]);
			end
			OP_AND:  exe.res = in_data.a & in_data.y;
			OP_NAND: exe.res = ~(in_data.a & in_data.y);
			OP_OR:   exe.res = in_data.a | in_data.y;
			OP_NOR:  exe.res = ~(in_data.a | in_data.y);
			OP_XOR:  exe.res = in_data.a ^ in_data.y;
			OP_NOTA: exe.res = ~in_data.a;
			OP_ASL, OP_ROL: begin
				exe.res = {in_data.a[DataW-2:0], in_data.ci};
				exe.c   = in_data.a[SignBit];
				exe.v   = in_data.a[SignBit] ^ in_data.a[SignBit-1];
			end
			OP_ASR, OP_ROR: begin
				exe.res = {in_data.ci, in_data.a[DataW-1:1]};
				exe.c   = in_data.a[0];
			end
			default: begin
				exe.nzvc = 1'b1;
				exe.v    = in_data.a[1];
				exe.c    = in_data.a[0];
			end
		endcase
	end

	assign in_ready = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= exe;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = data_s2;
endmodule
`default_nettype wire

[hw/rtl/alu8_flg.sv]
`default_nettype none
module alu8_flg (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  alu8_pkg::exe_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output alu8_pkg::rsp_t out_data
);
	import alu8_pkg::*;

	rsp_t rsp;
	logic vld_s3;
	rsp_t data_s3;

	// Derive N and Z, zero everything when an operand was missing
	always_comb begin
		rsp = '0;
		if (in_data.ok) begin
			rsp.result_byte  = in_data.res;
			rsp.flag_v       = in_data.v;
			rsp.flag_c       = in_data.c;
			rsp.result_valid = 1'b1;
			if (in_data.nzvc) begin
				rsp.flag_n = in_data.alt_n;
				rsp.flag_z = in_data.alt_z;
			end else begin
				rsp.flag_n = in_data.res[SignBit];
				rsp.flag_z = (in_data.res == '0);
			end
		end
	end

	// Hold the result until the sink takes it
	assign in_ready = !vld_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= rsp;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = data_s3;
endmodule
`default_nettype wire

[verif/testbench.sv]
module testbench;
	import alu8_pkg::*;

	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned HoldCycles = 80;
	localparam int unsigned DrainCycles = 10;

	logic clk;
	logic arst_n;

	alu8_req_if req_ch ();
	alu8_rsp_if rsp_ch ();

	eight_bit_alu_nzvc u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rsp_t pending_results[$];
	int   mismatches = 0;
	int   requests_sent = 0;
	int   results_checked = 0;
	int   idle_cycles = 0;
	int   burst_left = 1;
	bit   tx_steady = 1'b0;
	bit   rx_steady = 1'b0;
	bit   rx_hold_req = 1'b0;
	int   rx_hold_left = 0;
	logic [7:0] stall_lfsr = 8'hA5;

	// Free-running clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Work out the response the ALU owes for one request
	function automatic rsp_t compute_alu_result(op_t op, logic [7:0] a, logic a_p,
			logic [7:0] b, logic b_p, logic ci, logic ci_p);
		rsp_t       r;
		logic       unary;
		logic       needs_ci;
		logic [7:0] bb;
		logic [7:0] res;
		logic [8:0] sum;
		logic       cin;
		logic       v;
		logic       c;
		r = '0;
		unary = (op == OP_MOVA) || (op == OP_NOTA) || (op == OP_ASL) || (op == OP_ROL) ||
			(op == OP_ASR) || (op == OP_ROR) || (op == OP_NZVC);
		needs_ci = (op == OP_ADC) || (op == OP_SBC) || (op == OP_ROL) || (op == OP_ROR);
		// missing operand: everything zero, not valid
		if (!a_p || (!unary && !b_p) || (needs_ci && !ci_p))
			return r;
		res = 8'h00;
		v = 1'b0;
		c = 1'b0;
		case (op)
			OP_MOVA: res = a;
			OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
				bb = (op == OP_SUB || op == OP_SBC) ? ~b : b;
				cin = (op == OP_ADD) ? 1'b0 : (op == OP_SUB) ? 1'b1 : ci;
				sum = {1'b0, a} + {1'b0, bb} + {8'h00, cin};
				res = sum[7:0];
				c = sum[8];
				v = (a[7] == bb[7]) && (res[7] != a[7]);
			end
			OP_AND:  res = a & b;
			OP_NAND: res = ~(a & b);
			OP_OR:   res = a | b;
			OP_NOR:  res = ~(a | b);
			OP_XOR:  res = a ^ b;
			OP_NOTA: res = ~a;
			OP_ASL, OP_ROL: begin
				res = {a[6:0], (op == OP_ROL) ? ci : 1'b0};
				c = a[7];
				v = a[7] ^ a[6];
			end
			OP_ASR, OP_ROR: begin
				res = {(op == OP_ASR) ? a[7] : ci, a[7:1]};
				c = a[0];
			end
			OP_NZVC: begin
				// flags come straight from the low nibble of A
				r.flag_n = a[3];
				r.flag_z = a[2];
				r.flag_v = a[1];
				r.flag_c = a[0];
				r.result_valid = 1'b1;
				return r;
			end
			default: res = 8'h00;
		endcase
		r.result_byte = res;
		r.flag_n = res[7];
		r.flag_z = (res == 8'h00);
		r.flag_v = v;
		r.flag_c = c;
		r.result_valid = 1'b1;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one request, hold it until taken, then maybe pause
	task automatic send_request(op_t op, logic [7:0] a, logic a_p, logic [7:0] b,
			logic b_p, logic ci, logic ci_p);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.operand_a <= a;
		req_ch.a_present <= a_p;
		req_ch.operand_b <= b;
		req_ch.b_present <= b_p;
		req_ch.carry_in <= ci;
		req_ch.carry_in_present <= ci_p;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(compute_alu_result(op, a, a_p, b, b_p, ci, ci_p));
		requests_sent++;
		if (!tx_steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(1, 6);
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Compare each response against the oldest pending one
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding: result_byte 0x%0h",
					rsp_ch.result_byte);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_byte", int'(want.result_byte),
					int'(rsp_ch.result_byte));
				check_field("flag_n", int'(want.flag_n), int'(rsp_ch.flag_n));
				check_field("flag_z", int'(want.flag_z), int'(rsp_ch.flag_z));
				check_field("flag_v", int'(want.flag_v), int'(rsp_ch.flag_v));
				check_field("flag_c", int'(want.flag_c), int'(rsp_ch.flag_c));
				check_field("result_valid", int'(want.result_valid),
					int'(rsp_ch.result_valid));
				results_checked++;
			end
		end
	end

	// Drive response ready: long hold on request, steady, or LFSR pattern
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rx_hold_left--;
		end else if (rx_hold_req) begin
			rsp_ch.ready <= 1'b0;
			rx_hold_left = HoldCycles - 1;
			rx_hold_req = 1'b0;
		end else if (rx_steady) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			stall_lfsr = {stall_lfsr[6:0],
				stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
			rsp_ch.ready <= stall_lfsr[0] | stall_lfsr[2];
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Extremes of each function plus the named corner cases
	task automatic test_directed();
		for (int k = 0; k < 16; k++) begin
			if (k % 2 == 1)
				send_request(op_t'(k), 8'hFF, 1'b1, 8'h01, 1'b1, 1'b1, 1'b1);
			else
				send_request(op_t'(k), 8'h80, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b1);
		end
		// missing A, missing B, missing carry
		send_request(OP_MOVA, 8'h55, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1);
		send_request(OP_ADD, 8'h12, 1'b1, 8'h34, 1'b0, 1'b0, 1'b1);
		send_request(OP_ROL, 8'hC3, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
		// signed overflow on add
		send_request(OP_ADD, 8'h7F, 1'b1, 8'h01, 1'b1, 1'b0, 1'b0);
		// carry out of a three-operand add
		send_request(OP_ADC, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1);
		// equal subtract: zero and carry set
		send_request(OP_SUB, 8'h42, 1'b1, 8'h42, 1'b1, 1'b0, 1'b0);
		send_request(OP_SBC, 8'h00, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b1);
		// left shift overflow, then flags from the low nibble
		send_request(OP_ASL, 8'h40, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
		send_request(OP_NZVC, 8'hF0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
	endtask

	// Mostly complete requests, some with presence bits dropped
	task automatic test_random(int count);
		op_t        op;
		logic [7:0] a;
		logic [7:0] b;
		logic       ci;
		logic       a_p;
		logic       b_p;
		logic       ci_p;
		for (int i = 0; i < count; i++) begin
			op = op_t'($urandom_range(0, 15));
			a = 8'($urandom_range(0, 255));
			b = 8'($urandom_range(0, 255));
			ci = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 99) < 85) begin
				a_p = 1'b1;
				b_p = 1'b1;
				ci_p = 1'b1;
			end else begin
				a_p = 1'($urandom_range(0, 1));
				b_p = 1'($urandom_range(0, 1));
				ci_p = 1'($urandom_range(0, 1));
			end
			send_request(op, a, a_p, b, b_p, ci, ci_p);
		end
	endtask

	// Hold off the receiver while requests keep coming
	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		tx_steady = 1'b1;
		test_random(40);
		tx_steady = 1'b0;
	endtask

	// Back-to-back requests with the receiver always ready
	task automatic test_back_to_back();
		rx_steady = 1'b1;
		tx_steady = 1'b1;
		test_random(100);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= OP_MOVA;
		req_ch.operand_a <= 8'h00;
		req_ch.a_present <= 1'b0;
		req_ch.operand_b <= 8'h00;
		req_ch.b_present <= 1'b0;
		req_ch.carry_in <= 1'b0;
		req_ch.carry_in_present <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(600);
		test_backpressure();
		test_back_to_back();
		test_random(600);

		// drain the pipeline
		req_ch.valid <= 1'b0;
		rx_steady = 1'b1;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d requests over all sixteen functions, missing operands included,",
			requests_sent);
		$display("under bursts, random and long output stalls; %0d responses checked.",
			results_checked);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
